/* rtl/pqd_pkg.sv */
// ----------------------------------------------------------------------------
// pqd_pkg: shared types and constants of the palette quantiser
// Configuration record, queue entry, status record, command and register
// codes, and the error-share arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package pqd_pkg;

  // command codes of an input item
  localparam logic CMD_PIXEL     = 1'b0;
  localparam logic CMD_PAL_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_PALETTE_COUNT      = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH        = 3'd1;
  localparam logic [2:0] REG_IMAGE_HEIGHT       = 3'd2;
  localparam logic [2:0] REG_DITHER_ENABLE      = 3'd3;
  localparam logic [2:0] REG_TRANSPARENCY_ENABLE = 3'd4;
  localparam logic [2:0] REG_TRANSPARENT_INDEX  = 3'd5;

  // diffusion weights, in sixteenths
  localparam logic [2:0] W_AHEAD  = 3'd7;
  localparam logic [2:0] W_BEHIND = 3'd3;
  localparam logic [2:0] W_BELOW  = 3'd5;
  localparam logic [2:0] W_DIAG   = 3'd1;

  localparam logic [7:0] CHAN_MAX = 8'd255;

  typedef struct packed {
    logic [8:0]  palette_count;
    logic [10:0] image_width;
    logic [15:0] image_height;
    logic        dither_enable;
    logic        transparency_enable;
    logic [7:0]  transp_idx;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    palette_count:       9'd256,
    image_width:         11'd1024,
    image_height:        16'd1,
    dither_enable:       1'b1,
    transparency_enable: 1'b0,
    transp_idx:          8'd0
  };

  // entry of the queue between front and back
  typedef struct packed {
    logic       is_write;
    logic       transparent;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] entry_slot;
  } q_item_t;

  // status from back to front
  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // (w*e+8)/16, truncated toward zero
  function automatic logic signed [8:0] fs_share(input logic [2:0] w,
                                                 input logic signed [8:0] e);
    logic signed [12:0] t;
    logic [12:0]        mag;
    logic [12:0]        q;
    t   = $signed({10'd0, w}) * $signed({{4{e[8]}}, e}) + 13'sd8;
    mag = t[12] ? 13'(-t) : 13'(t);
    q   = mag >> 4;
    return t[12] ? 9'(-q) : 9'(q);
  endfunction

endpackage

`default_nettype wire

/* rtl/pqd_if.sv */
// ----------------------------------------------------------------------------
// pqd_if: channel interfaces of the palette quantiser
// Pixel/palette item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pqd_item_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] entry_slot;
  modport source (output valid, cmd, red, green, blue, alpha, entry_slot, input ready);
  modport sink   (input valid, cmd, red, green, blue, alpha, entry_slot, output ready);
endinterface

interface pqd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;
  modport source (output valid, color_index, input ready);
  modport sink   (input valid, color_index, output ready);
endinterface

interface pqd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/palette_quantize_fs_dither.sv */
// ----------------------------------------------------------------------------
// palette_quantize_fs_dither: palette quantiser with serpentine dithering
// Nearest-colour palette mapping of RGBA pixels with Floyd-Steinberg error
// diffusion, transparent index and palette loading through the item channel.
// ----------------------------------------------------------------------------
//
//  channel   dir   transfer carries
//  -------   ---   ---------------------------------------------------------
//  items     in    cmd, red, green, blue, alpha, entry_slot (pixel or write)
//  results   out   color_index, one per pixel, none per palette write
//  cfg       in    index (register 0..5), data (write always taken)
//
//  a palette write is taken in the back end's idle state; a pixel is
//  compared with the n entries of the searched palette, stopping early
//  on an exact match (one entry read per cycle from the palette RAM)
//  every row end with dithering on clears the old current-row error store,
//  one entry a cycle over image_width entries; no item is taken meanwhile
//  after reset and a geometry or dither write both MAX_WIDTH-entry stores
//  clear; a two-entry queue keeps intake going while the back end searches
//  a stalled result holds the back end in its output step only
// ----------------------------------------------------------------------------
`default_nettype none

module palette_quantize_fs_dither #(
  parameter int MAX_WIDTH     = 1024,
  parameter int PALETTE_DEPTH = 256,
  parameter int ERROR_BITS    = 12
) (
  input  wire logic    clk,
  input  wire logic    rst,
  pqd_item_if.sink     items,
  pqd_result_if.source results,
  pqd_cfg_if.sink      cfg
);

  pqd_pkg::cfg_t       cfg_q;
  pqd_pkg::back_stat_t stat;
  pqd_pkg::q_item_t    q_item;
  logic                q_valid, q_ready;
  logic                restart;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;

  // geometry or dither mode change restarts the image
  assign restart = cfg.valid &&
                   (cfg.index == pqd_pkg::REG_IMAGE_WIDTH  ||
                    cfg.index == pqd_pkg::REG_IMAGE_HEIGHT ||
                    cfg.index == pqd_pkg::REG_DITHER_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= pqd_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pqd_pkg::REG_PALETTE_COUNT:       cfg_q.palette_count       <= cfg.data[8:0];
        pqd_pkg::REG_IMAGE_WIDTH:         cfg_q.image_width         <= cfg.data[10:0];
        pqd_pkg::REG_IMAGE_HEIGHT:        cfg_q.image_height        <= cfg.data;
        pqd_pkg::REG_DITHER_ENABLE:       cfg_q.dither_enable       <= cfg.data[0];
        pqd_pkg::REG_TRANSPARENCY_ENABLE: cfg_q.transparency_enable <= cfg.data[0];
        pqd_pkg::REG_TRANSPARENT_INDEX:   cfg_q.transp_idx          <= cfg.data[7:0];
        default: ; // unknown index, ignored
      endcase
    end
  end

  // intake, classification and queue
  pqd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .cfg     (cfg_q),
    .stat    (stat),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  // search, diffusion and result register
  pqd_back #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .ERROR_BITS    (ERROR_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_q),
    .restart (restart),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .stat    (stat),
    .results (results)
  );

endmodule

`default_nettype wire

/* rtl/pqd_ram.sv */
// ----------------------------------------------------------------------------
// pqd_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pqd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/pqd_front.sv */
// ----------------------------------------------------------------------------
// pqd_front: item intake and classification
// Tags each item as palette write or pixel, flags transparent pixels and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pqd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  pqd_item_if.sink                items,
  input  wire pqd_pkg::cfg_t      cfg,
  input  wire pqd_pkg::back_stat_t stat,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output pqd_pkg::q_item_t        q_item
);

  pqd_pkg::q_item_t slots [2];
  pqd_pkg::q_item_t ent;
  logic             wp, rp;
  logic [1:0]       cnt;
  logic             push, pop;

  assign items.ready = (cnt != 2'd2) && !stat.clearing;
  assign push        = items.valid && items.ready;
  assign q_valid     = (cnt != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_item      = slots[rp];

  always_comb begin
    ent.is_write    = (items.cmd == pqd_pkg::CMD_PAL_WRITE);
    ent.transparent = cfg.transparency_enable && (items.alpha == 8'd0);
    ent.red         = items.red;
    ent.green       = items.green;
    ent.blue        = items.blue;
    ent.entry_slot  = items.entry_slot;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/pqd_back.sv */
// ----------------------------------------------------------------------------
// pqd_back: search and diffusion engine
// Palette writes, nearest-colour search one entry a cycle, error
// application and spreading, row bookkeeping and error store clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module pqd_back #(
  parameter int MAX_WIDTH     = 1024,
  parameter int PALETTE_DEPTH = 256,
  parameter int ERROR_BITS    = 12
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pqd_pkg::cfg_t       cfg,
  input  wire logic                restart,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire pqd_pkg::q_item_t    q_item,
  output pqd_pkg::back_stat_t      stat,
  pqd_result_if.source             results
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int IW = $clog2(PALETTE_DEPTH);
  localparam int EB = ERROR_BITS;
  localparam int EW = 3 * EB;

  typedef enum logic [3:0] {
    S_IDLE, S_RDCUR, S_ADJ, S_SRCH, S_ERR, S_OPRD, S_OPWR, S_OUT, S_CLR
  } state_t;

  state_t               state;
  pqd_pkg::q_item_t     item;
  logic [AW-1:0]        col;
  logic [15:0]          row;
  logic                 sel;
  logic [7:0]           px_adj [3];
  logic [IW-1:0]        iss_idx, rd_idx, sq_idx, best;
  logic                 iss_on, rd_v, sq_v;
  logic [15:0]          sq [3];
  logic [23:0]          sq_rgb, best_rgb;
  logic [17:0]          bestd;
  logic signed [8:0]    err [3];
  logic [1:0]           op;
  logic [AW-1:0]        clr_addr;
  logic                 clr_all;
  logic                 res_v;
  logic [7:0]           res_idx;

  // derived geometry
  logic [WW-1:0]        w_eff;
  logic [15:0]          h_eff;
  logic [IW-1:0]        n_last;
  logic [AW-1:0]        x, xa, xb, clr_last;
  logic                 ahead, behind, last_row;

  // memory ports
  logic                 pal_we;
  logic [23:0]          pal_rdata;
  logic                 e_we [2];
  logic [AW-1:0]        e_waddr [2];
  logic [EW-1:0]        e_wdata [2];
  logic [AW-1:0]        e_raddr [2];
  logic [EW-1:0]        e_rdata [2];

  // datapath
  logic [15:0]          sqn [3];
  logic [17:0]          dsum;
  logic [7:0]           adj [3];
  logic signed [8:0]    errn [3];
  logic                 op_en, op_cur, op_tgt;
  logic [AW-1:0]        op_addr;
  logic [2:0]           op_w;
  logic [EW-1:0]        op_new;
  logic [EW-1:0]        cur_cell;
  logic                 out_go;

  always_comb begin
    if (cfg.image_width == 11'd0) begin
      w_eff = WW'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.image_width);
    end
    h_eff = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
    if (cfg.palette_count == 9'd0) begin
      n_last = '0;
    end else if (32'(cfg.palette_count) > 32'(PALETTE_DEPTH)) begin
      n_last = IW'(PALETTE_DEPTH - 1);
    end else begin
      n_last = IW'(cfg.palette_count - 9'd1);
    end
  end

  assign x        = row[0] ? (AW'(w_eff - WW'(1)) - col) : col;
  assign xa       = row[0] ? (x - AW'(1)) : (x + AW'(1));
  assign xb       = row[0] ? (x + AW'(1)) : (x - AW'(1));
  assign ahead    = (WW'(col) + WW'(1)) < w_eff;
  assign behind   = (col != '0);
  assign last_row = (17'(row) + 17'd1) >= 17'(h_eff);
  assign clr_last = clr_all ? AW'(MAX_WIDTH - 1) : AW'(w_eff - WW'(1));

  assign q_ready        = (state == S_IDLE);
  assign stat.clearing  = (state == S_CLR);
  assign results.valid       = res_v;
  assign results.color_index = res_idx;
  assign out_go         = (state == S_OUT) && (!res_v || results.ready);

  // palette store
  assign pal_we = q_valid && q_ready && q_item.is_write &&
                  ({1'b0, q_item.entry_slot} < 9'(PALETTE_DEPTH));

  pqd_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal (
    .clk   (clk),
    .we    (pal_we),
    .waddr (q_item.entry_slot[IW-1:0]),
    .wdata ({q_item.red, q_item.green, q_item.blue}),
    .raddr (iss_idx),
    .rdata (pal_rdata)
  );

  // error stores, sel picks the current row
  for (genvar k = 0; k < 2; k++) begin : g_err
    pqd_ram #(.WIDTH(EW), .DEPTH(MAX_WIDTH)) u_err (
      .clk   (clk),
      .we    (e_we[k]),
      .waddr (e_waddr[k]),
      .wdata (e_wdata[k]),
      .raddr (e_raddr[k]),
      .rdata (e_rdata[k])
    );
  end

  // distance of the entry just read
  always_comb begin
    logic signed [8:0]  dif;
    logic signed [17:0] p;
    for (int c = 0; c < 3; c++) begin
      dif    = $signed({1'b0, px_adj[c]}) - $signed({1'b0, pal_rdata[(2-c)*8 +: 8]});
      p      = dif * dif;
      sqn[c] = p[15:0];
    end
    dsum = 18'(sq[0]) + 18'(sq[1]) + 18'(sq[2]);
  end

  // stored error applied and clamped, red in the top bits
  assign cur_cell = e_rdata[sel];
  always_comb begin
    logic signed [EB+1:0] v;
    logic [7:0]           raw [3];
    raw[0] = item.red;
    raw[1] = item.green;
    raw[2] = item.blue;
    for (int c = 0; c < 3; c++) begin
      v = $signed({{(EB-6){1'b0}}, raw[c]}) +
          $signed({{2{cur_cell[(2-c)*EB + EB-1]}}, cur_cell[(2-c)*EB +: EB]});
      if (v < 0) begin
        adj[c] = 8'd0;
      end else if (v > $signed((EB+2)'(pqd_pkg::CHAN_MAX))) begin
        adj[c] = pqd_pkg::CHAN_MAX;
      end else begin
        adj[c] = v[7:0];
      end
    end
    for (int c = 0; c < 3; c++) begin
      errn[c] = $signed({1'b0, px_adj[c]}) - $signed({1'b0, best_rgb[(2-c)*8 +: 8]});
    end
  end

  // spreading steps
  always_comb begin
    unique case (op)
      2'd0: begin
        op_en = ahead; op_cur = 1'b1; op_addr = xa; op_w = pqd_pkg::W_AHEAD;
      end
      2'd1: begin
        op_en = !last_row && behind; op_cur = 1'b0; op_addr = xb; op_w = pqd_pkg::W_BEHIND;
      end
      2'd2: begin
        op_en = !last_row; op_cur = 1'b0; op_addr = x; op_w = pqd_pkg::W_BELOW;
      end
      default: begin
        op_en = !last_row && ahead; op_cur = 1'b0; op_addr = xa; op_w = pqd_pkg::W_DIAG;
      end
    endcase
    op_tgt = op_cur ? sel : ~sel;
  end

  always_comb begin
    logic signed [EB:0] s;
    logic signed [8:0]  sh;
    logic [EW-1:0]      tgt_word;
    tgt_word = e_rdata[op_tgt];
    for (int c = 0; c < 3; c++) begin
      sh = pqd_pkg::fs_share(op_w, err[c]);
      s  = $signed({tgt_word[(2-c)*EB + EB-1], tgt_word[(2-c)*EB +: EB]}) +
           $signed({{(EB-8){sh[8]}}, sh});
      if (s[EB] != s[EB-1]) begin
        op_new[(2-c)*EB +: EB] = s[EB] ? {1'b1, {(EB-1){1'b0}}} : {1'b0, {(EB-1){1'b1}}};
      end else begin
        op_new[(2-c)*EB +: EB] = s[EB-1:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      e_we[k]    = 1'b0;
      e_waddr[k] = clr_addr;
      e_wdata[k] = '0;
      e_raddr[k] = x;
    end
    unique case (state)
      S_OPRD: e_raddr[op_tgt] = op_addr;
      S_OPWR: begin
        e_we[op_tgt]    = 1'b1;
        e_waddr[op_tgt] = op_addr;
        e_wdata[op_tgt] = op_new;
      end
      S_CLR: begin
        e_we[~sel] = 1'b1;
        if (clr_all) e_we[sel] = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_all  <= 1'b1;
      clr_addr <= '0;
      col      <= '0;
      row      <= '0;
      sel      <= 1'b0;
      res_v    <= 1'b0;
      iss_on   <= 1'b0;
      rd_v     <= 1'b0;
      sq_v     <= 1'b0;
    end else begin
      if (results.ready) res_v <= 1'b0;
      if (restart) begin
        state    <= S_CLR;
        clr_all  <= 1'b1;
        clr_addr <= '0;
        col      <= '0;
        row      <= '0;
        sel      <= 1'b0;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (q_valid && !q_item.is_write) begin
              item <= q_item;
              if (q_item.transparent) begin
                state <= S_OUT;
              end else if (cfg.dither_enable) begin
                state <= S_RDCUR;
              end else begin
                px_adj[0] <= q_item.red;
                px_adj[1] <= q_item.green;
                px_adj[2] <= q_item.blue;
                iss_idx <= '0;
                iss_on  <= 1'b1;
                rd_v    <= 1'b0;
                sq_v    <= 1'b0;
                bestd   <= '1;
                best    <= '0;
                state   <= S_SRCH;
              end
            end
          end
          S_RDCUR: state <= S_ADJ;
          S_ADJ: begin
            px_adj  <= adj;
            iss_idx <= '0;
            iss_on  <= 1'b1;
            rd_v    <= 1'b0;
            sq_v    <= 1'b0;
            bestd   <= '1;
            best    <= '0;
            state   <= S_SRCH;
          end
          S_SRCH: begin
            rd_v   <= iss_on;
            rd_idx <= iss_idx;
            if (iss_on) begin
              if (iss_idx == n_last) iss_on <= 1'b0;
              else iss_idx <= iss_idx + IW'(1);
            end
            sq_v   <= rd_v;
            sq_idx <= rd_idx;
            sq     <= sqn;
            sq_rgb <= pal_rdata;
            if (sq_v) begin
              if (dsum < bestd) begin
                bestd    <= dsum;
                best     <= sq_idx;
                best_rgb <= sq_rgb;
              end
              if (sq_idx == n_last || dsum == 18'd0) begin
                iss_on <= 1'b0;
                rd_v   <= 1'b0;
                sq_v   <= 1'b0;
                state  <= cfg.dither_enable ? S_ERR : S_OUT;
              end
            end
          end
          S_ERR: begin
            err   <= errn;
            op    <= 2'd0;
            state <= S_OPRD;
          end
          S_OPRD: begin
            if (op_en) state <= S_OPWR;
            else if (op == 2'd3) state <= S_OUT;
            else op <= op + 2'd1;
          end
          S_OPWR: begin
            if (op == 2'd3) begin
              state <= S_OUT;
            end else begin
              op    <= op + 2'd1;
              state <= S_OPRD;
            end
          end
          S_OUT: begin
            if (out_go) begin
              res_v   <= 1'b1;
              res_idx <= item.transparent ? cfg.transp_idx : 8'(best);
              if (ahead) begin
                col   <= col + AW'(1);
                state <= S_IDLE;
              end else begin
                col <= '0;
                row <= last_row ? 16'd0 : row + 16'd1;
                if (cfg.dither_enable) begin
                  sel      <= ~sel;
                  clr_all  <= 1'b0;
                  clr_addr <= '0;
                  state    <= S_CLR;
                end else begin
                  state <= S_IDLE;
                end
              end
            end
          end
          S_CLR: begin
            if (clr_addr == clr_last) state <= S_IDLE;
            else clr_addr <= clr_addr + AW'(1);
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    WW'(col) < w_eff)
    else $error("column counter beyond row width");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERR) |-> (best <= n_last))
    else $error("chosen index outside searched palette");

  a_dual_write: assert property (@(posedge clk) disable iff (rst)
    (e_we[0] && e_we[1]) |-> (state == S_CLR && clr_all))
    else $error("both error stores written outside full clear");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (out_go && !restart) |=> res_v)
    else $error("finished pixel produced no result");

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for palette_quantize_fs_dither
// Loads a palette, then runs directed and random pixel streams over several
// geometry, dithering and transparency settings. A scoreboard predicts every
// colour index (serpentine error diffusion included) and checks each result.
// ----------------------------------------------------------------------------

module testbench;

  // scoreboard: tracks palette, error stores and position, predicts indexes
  class pqd_scoreboard;
    int unsigned palette_count, image_width, image_height;
    bit          dither_on, transp_on;
    logic [7:0]  transp_idx;
    logic [23:0] palette[256];
    int          err[2][1024][3];
    int          cur_sel, column, row;
    logic [7:0]  index_q[$];
    int          fails;

    function new();
      palette_count = 256;
      image_width   = 1024;
      image_height  = 1;
      dither_on     = 1;
      transp_on     = 0;
      transp_idx    = 0;
      fails         = 0;
      foreach (palette[i]) palette[i] = '0;
      restart_image();
    endfunction

    function void restart_image();
      foreach (err[s, x, c]) err[s][x][c] = 0;
      cur_sel = 0;
      column  = 0;
      row     = 0;
    endfunction

    function void write_reg(logic [2:0] index, logic [15:0] data);
      case (index)
        pqd_pkg::REG_PALETTE_COUNT:       palette_count = 32'(data[8:0]);
        pqd_pkg::REG_IMAGE_WIDTH:         begin
          image_width = 32'(data[10:0]);
          restart_image();
        end
        pqd_pkg::REG_IMAGE_HEIGHT:        begin
          image_height = 32'(data);
          restart_image();
        end
        pqd_pkg::REG_DITHER_ENABLE:       begin dither_on = data[0]; restart_image(); end
        pqd_pkg::REG_TRANSPARENCY_ENABLE: transp_on = data[0];
        pqd_pkg::REG_TRANSPARENT_INDEX:   transp_idx = data[7:0];
        default: ;
      endcase
    endfunction

    function int sat_err(int v);
      if (v > 2047) return 2047;
      if (v < -2048) return -2048;
      return v;
    endfunction

    function void spread(int s, int x, int e[3], int w);
      for (int c = 0; c < 3; c++)
        err[s][x][c] = sat_err(err[s][x][c] + (w * e[c] + 8) / 16);
    endfunction

    function int chan(logic [23:0] entry, int c);
      return int'((entry >> (16 - 8 * c)) & 24'hff);
    endfunction

    // squared distance search, first index wins ties, stops on exact match
    function int closest(int px[3]);
      int n, best, d, t;
      longint bestd;
      n = (palette_count > 256) ? 256 : palette_count;
      best = 0;
      bestd = 64'hffff_ffff;
      for (int i = 0; i < n && bestd != 0; i++) begin
        d = 0;
        for (int c = 0; c < 3; c++) begin
          t = px[c] - chan(palette[i], c);
          d += t * t;
        end
        if (d < bestd) begin
          bestd = d;
          best = i;
        end
      end
      return best;
    endfunction

    function void note_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] a, logic [7:0] slot);
      int w, h, col, x, xa, xb, idx, v, nx;
      bit odd, last_row;
      int px[3], e[3];
      if (cmd == pqd_pkg::CMD_PAL_WRITE) begin
        palette[slot] = {r, g, b};
        return;
      end
      w = (image_width == 0) ? 1 : (image_width > 1024 ? 1024 : image_width);
      h = (image_height == 0) ? 1 : image_height;
      if (column >= w) column = 0;
      if (row >= h) row = 0;
      col = column;
      odd = row[0];
      last_row = (row + 1 >= h);
      px[0] = int'(r);
      px[1] = int'(g);
      px[2] = int'(b);
      if (transp_on && a == 0) begin
        idx = int'(transp_idx);
      end else if (!dither_on) begin
        idx = closest(px);
      end else begin
        nx = cur_sel ^ 1;
        x  = odd ? (w - 1 - col) : col;
        xa = odd ? x - 1 : x + 1;
        xb = odd ? x + 1 : x - 1;
        for (int c = 0; c < 3; c++) begin
          v = px[c] + err[cur_sel][x][c];
          px[c] = (v < 0) ? 0 : (v > 255 ? 255 : v);
        end
        idx = closest(px);
        for (int c = 0; c < 3; c++) e[c] = px[c] - chan(palette[idx & 8'hff], c);
        if (col + 1 < w) spread(cur_sel, xa, e, int'(pqd_pkg::W_AHEAD));
        if (!last_row) begin
          if (col > 0) spread(nx, xb, e, int'(pqd_pkg::W_BEHIND));
          spread(nx, x, e, int'(pqd_pkg::W_BELOW));
          if (col + 1 < w) spread(nx, xa, e, int'(pqd_pkg::W_DIAG));
        end
      end
      column = col + 1;
      if (column >= w) begin
        column = 0;
        cur_sel ^= 1;
        for (int i = 0; i < 1024; i++)
          for (int c = 0; c < 3; c++) err[cur_sel ^ 1][i][c] = 0;
        row = last_row ? 0 : row + 1;
      end
      index_q.push_back(idx[7:0]);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fails++;
    endtask

    task check_result(logic [7:0] got);
      logic [7:0] want;
      if (index_q.size() == 0) begin
        report($sformatf("unexpected colour index %0d", got));
      end else begin
        want = index_q.pop_front();
        if (got !== want) report($sformatf("colour index %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  pqd_item_if   items_ch();
  pqd_result_if res_ch();
  pqd_cfg_if    cfg_ch();

  pqd_scoreboard sb = new();

  bit quiet;        // no idling on either side
  bit hold_req;     // asks the result side for a long hold-off
  int idle_odds;    // sender idles on one item in idle_odds, 0 means never
  int unsigned cycles;

  palette_quantize_fs_dither dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit, far above the slowest correct run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result checking on every transfer
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.color_index);
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    res_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        res_ch.ready <= 1'b1;
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end
    end
  end

  // one item transfer, with an optional idle burst in front
  task send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                 logic [7:0] a, logic [7:0] slot);
    if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      items_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    items_ch.valid      <= 1'b1;
    items_ch.cmd        <= cmd;
    items_ch.red        <= r;
    items_ch.green      <= g;
    items_ch.blue       <= b;
    items_ch.alpha      <= a;
    items_ch.entry_slot <= slot;
    do @(posedge clk); while (!items_ch.ready);
    sb.note_item(cmd, r, g, b, a, slot);
  endtask

  // random pixel, zero alpha now and then, occasional palette rewrite
  task send_random();
    logic [7:0] a;
    a = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
    if ($urandom_range(0, 9) == 0)
      send_item(pqd_pkg::CMD_PAL_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
    else
      send_item(pqd_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                a, 8'($urandom));
  endtask

  // lower valid and wait for every predicted index, then for the back end
  task drain(int settle);
    items_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.index_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task write_reg(logic [2:0] index, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(index, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task set_mode(int cnt, int w, int h, int dith, int te, int ti);
    write_reg(pqd_pkg::REG_PALETTE_COUNT, 16'(cnt));
    write_reg(pqd_pkg::REG_IMAGE_WIDTH, 16'(w));
    write_reg(pqd_pkg::REG_IMAGE_HEIGHT, 16'(h));
    write_reg(pqd_pkg::REG_DITHER_ENABLE, 16'(dith));
    write_reg(pqd_pkg::REG_TRANSPARENCY_ENABLE, 16'(te));
    write_reg(pqd_pkg::REG_TRANSPARENT_INDEX, 16'(ti));
  endtask

  initial begin
    int n_px;
    quiet                = 0;
    hold_req             = 0;
    idle_odds            = 4;
    rst                 <= 1'b1;
    items_ch.valid      <= 1'b0;
    items_ch.cmd        <= pqd_pkg::CMD_PIXEL;
    items_ch.red        <= '0;
    items_ch.green      <= '0;
    items_ch.blue       <= '0;
    items_ch.alpha      <= '0;
    items_ch.entry_slot <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= pqd_pkg::REG_PALETTE_COUNT;
    cfg_ch.data         <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // whole palette first, so no search ever meets an unwritten slot;
    // black, white and a duplicated grey pair for the tie rule
    for (int i = 0; i < 256; i++) begin
      case (i)
        0:       send_item(pqd_pkg::CMD_PAL_WRITE, 8'h00, 8'h00, 8'h00, 8'($urandom), 8'(i));
        1, 255:  send_item(pqd_pkg::CMD_PAL_WRITE, 8'hff, 8'hff, 8'hff, 8'($urandom), 8'(i));
        2, 3:    send_item(pqd_pkg::CMD_PAL_WRITE, 8'h80, 8'h80, 8'h80, 8'($urandom), 8'(i));
        default: send_item(pqd_pkg::CMD_PAL_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), 8'(i));
      endcase
    end

    // directed pixels under reset settings: extremes, exact hits, ties
    send_item(pqd_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(pqd_pkg::CMD_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(pqd_pkg::CMD_PIXEL, 8'h80, 8'h80, 8'h80, 8'hff, 8'h00);
    send_item(pqd_pkg::CMD_PIXEL, 8'h7f, 8'h81, 8'h80, 8'h01, 8'h00);
    send_item(pqd_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'hff, 8'h80, 8'h00);
    send_item(pqd_pkg::CMD_PAL_WRITE, 8'h12, 8'h34, 8'h56, 8'h00, 8'd7);
    send_item(pqd_pkg::CMD_PIXEL, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00);
    send_item(pqd_pkg::CMD_PIXEL, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00);
    send_item(pqd_pkg::CMD_PIXEL, 8'h01, 8'h01, 8'h01, 8'hfe, 8'h00);
    send_item(pqd_pkg::CMD_PIXEL, 8'hfe, 8'hfe, 8'hfe, 8'h7f, 8'h00);
    drain(1100);

    // tie between the grey pair, transparent pixels and both alpha extremes
    set_mode(4, 3, 2, 1, 1, 255);
    send_item(pqd_pkg::CMD_PIXEL, 8'h70, 8'h70, 8'h70, 8'hff, 8'h00);
    send_item(pqd_pkg::CMD_PIXEL, 8'h10, 8'hf0, 8'h33, 8'h00, 8'h00);
    send_item(pqd_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'h00, 8'h01, 8'h00);
    send_item(pqd_pkg::CMD_PIXEL, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00);
    send_item(pqd_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'hff, 8'hff, 8'h00);
    send_item(pqd_pkg::CMD_PIXEL, 8'h40, 8'h40, 8'h40, 8'h80, 8'h00);
    drain(1100);

    // random phases over many settings, extremes first
    for (int p = 0; p < 14; p++) begin
      n_px = 108;
      idle_odds = (p % 3 == 2) ? 0 : $urandom_range(2, 8);
      case (p)
        0:  set_mode(4, 5, 3, 1, 1, 255);
        1:  set_mode(0, 1, 1, 1, 0, 0);
        2:  begin set_mode(511, 2047, 2, 1, 1, $urandom_range(0, 255)); n_px = 40; end
        3:  set_mode(8, 3, 0, 1, 1, 0);
        4:  set_mode(16, 0, 65535, 0, 0, $urandom_range(0, 255));
        5:  set_mode(1, 7, 4, 1, 0, 0);
        6:  set_mode(256, 4, 3, 0, 1, 17);
        default: set_mode($urandom_range(1, 16), $urandom_range(1, 12),
                          $urandom_range(1, 6), $urandom_range(0, 1),
                          $urandom_range(0, 1), $urandom_range(0, 255));
      endcase
      if (p == 6) n_px = 30;
      if (p == 13) quiet = 1;
      for (int k = 0; k < n_px; k++) begin
        // long result hold-off while items keep coming, block fills up
        if (p == 3 && k == 20) hold_req = 1;
        // sender pause until every outstanding index has come back
        if (p == 5 && k == 50) drain(0);
        send_random();
      end
      drain(1100);
    end

    if (sb.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pqd_pkg.sv
rtl/pqd_if.sv
rtl/pqd_ram.sv
rtl/pqd_front.sv
rtl/pqd_back.sv
rtl/palette_quantize_fs_dither.sv
bench/testbench.sv
